### sv/crcoal_pkg.sv
package crcoal_pkg;

   // Defaults for the top-level parameters.
   localparam int unsigned SECTOR_SHIFT_DEFAULT = 9;
   localparam int unsigned QUEUE_DEPTH_DEFAULT  = 4;

   // Reset value of the sectors-per-block register.
   localparam logic [2:0] LOG2_SPB_RESET = 3'd1;

   // Codes of the request_kind field.
   localparam logic KIND_READ      = 1'b0;
   localparam logic KIND_ZERO_FILL = 1'b1;

   typedef struct packed {
      logic        request_kind;
      logic [39:0] start_sector;
      logic [15:0] first_skip;
      logic [31:0] length_bytes;
      logic [31:0] target_address;
      logic        final_result;
   } result_type;

   // One queue entry: all results caused by one input transaction.
   typedef struct packed {
      logic       two_results;
      result_type first;
      result_type second;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage

### sv/crcoal_req_if.sv
interface crcoal_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] block_number;
   logic [15:0] skip_bytes;
   logic [16:0] byte_count;
   logic [31:0] dest_address;
   logic        last_block;

   modport source (
      output valid, block_number, skip_bytes, byte_count, dest_address, last_block,
      input  ready
   );
   modport sink (
      input  valid, block_number, skip_bytes, byte_count, dest_address, last_block,
      output ready
   );
endinterface

### sv/crcoal_rsp_if.sv
interface crcoal_rsp_if;
   logic        valid;
   logic        ready;
   logic        request_kind;
   logic [39:0] start_sector;
   logic [15:0] first_skip;
   logic [31:0] length_bytes;
   logic [31:0] target_address;
   logic        final_result;

   modport source (
      output valid, request_kind, start_sector, first_skip, length_bytes, target_address,
             final_result,
      input  ready
   );
   modport sink (
      input  valid, request_kind, start_sector, first_skip, length_bytes, target_address,
             final_result,
      output ready
   );
endinterface

### sv/crcoal_front.sv
module crcoal_front
   import crcoal_pkg::*;
#(
   parameter int unsigned SECTOR_SHIFT = SECTOR_SHIFT_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [2:0]         log2_spb,
   crcoal_req_if.sink         req_chan,
   input  logic               push_ready,
   output push_type           push
);

   // Largest block size is 1 << (SECTOR_SHIFT + 7).
   localparam int unsigned BSIZE_W = SECTOR_SHIFT + 8;

   logic        pend_valid_ff, pend_valid_in;
   logic [39:0] pend_start_ff, pend_start_in;
   logic [31:0] pend_length_ff, pend_length_in;
   logic [15:0] pend_skip_ff, pend_skip_in;
   logic [31:0] pend_dest_ff, pend_dest_in;
   logic [39:0] expected_ff, expected_in;

   logic               accept;
   logic               mapped;
   logic               hit;
   logic               flush_old;
   logic               has_second;
   logic [39:0]        sector;
   logic [39:0]        advance;
   logic [BSIZE_W-1:0] bsize;
   logic [BSIZE_W-1:0] skip_ext;
   logic [BSIZE_W-1:0] fill;
   result_type         old_res;
   result_type         second_res;

   assign req_chan.ready = push_ready;
   assign accept = req_chan.valid && push_ready;

   always_comb begin
      mapped   = (req_chan.block_number != '0);
      sector   = 40'(req_chan.block_number) << log2_spb;
      advance  = 40'(req_chan.byte_count >> SECTOR_SHIFT);
      hit      = pend_valid_ff && (expected_ff == sector);
      bsize    = {{(BSIZE_W-1){1'b0}}, 1'b1} << (SECTOR_SHIFT + 32'(log2_spb));
      skip_ext = BSIZE_W'(req_chan.skip_bytes);
      fill     = (skip_ext >= bsize) ? '0 : bsize - skip_ext;

      // Pending read update.
      pend_start_in  = pend_start_ff;
      pend_length_in = pend_length_ff;
      pend_skip_in   = pend_skip_ff;
      pend_dest_in   = pend_dest_ff;
      expected_in    = expected_ff;
      if (mapped && hit) begin
         pend_length_in = pend_length_ff + 32'(req_chan.byte_count);
         expected_in    = expected_ff + advance;
      end else if (mapped) begin
         pend_start_in  = sector;
         pend_length_in = 32'(req_chan.byte_count);
         pend_skip_in   = req_chan.skip_bytes;
         pend_dest_in   = req_chan.dest_address;
         expected_in    = sector + advance;
      end
      pend_valid_in = mapped && !req_chan.last_block;

      // The old pending read leaves on a hole or on a block that does not follow on.
      flush_old  = pend_valid_ff && (!mapped || !hit);
      has_second = !mapped || req_chan.last_block;

      old_res.request_kind   = KIND_READ;
      old_res.start_sector   = pend_start_ff;
      old_res.first_skip     = pend_skip_ff;
      old_res.length_bytes   = pend_length_ff;
      old_res.target_address = pend_dest_ff;
      old_res.final_result   = !has_second;

      if (!mapped) begin
         second_res.request_kind   = KIND_ZERO_FILL;
         second_res.start_sector   = '0;
         second_res.first_skip     = '0;
         second_res.length_bytes   = 32'(fill);
         second_res.target_address = req_chan.dest_address;
      end else begin
         second_res.request_kind   = KIND_READ;
         second_res.start_sector   = pend_start_in;
         second_res.first_skip     = pend_skip_in;
         second_res.length_bytes   = pend_length_in;
         second_res.target_address = pend_dest_in;
      end
      second_res.final_result = 1'b1;

      push.valid             = accept && (flush_old || has_second);
      push.entry.two_results = flush_old && has_second;
      push.entry.first       = flush_old ? old_res : second_res;
      push.entry.second      = second_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (accept) begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_start_ff  <= pend_start_in;
         pend_length_ff <= pend_length_in;
         pend_skip_ff   <= pend_skip_in;
         pend_dest_ff   <= pend_dest_in;
         expected_ff    <= expected_in;
      end
   end

endmodule

### sv/crcoal_queue.sv
module crcoal_queue
   import crcoal_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     push_ready,
   output head_type head,
   input  logic     pop
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type        store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = store_ff[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

### sv/crcoal_back.sv
module crcoal_back
   import crcoal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  head_type    head,
   output logic        pop,
   crcoal_rsp_if.source rsp_chan
);

   entry_type  cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic       second_ff, second_in;
   logic       taken;
   logic       done;
   result_type sel;

   assign sel   = second_ff ? cur_ff.second : cur_ff.first;
   assign taken = cur_valid_ff && rsp_chan.ready;
   assign done  = taken && (second_ff || !cur_ff.two_results);
   assign pop   = (!cur_valid_ff || done) && head.valid;

   assign rsp_chan.valid          = cur_valid_ff;
   assign rsp_chan.request_kind   = sel.request_kind;
   assign rsp_chan.start_sector   = sel.start_sector;
   assign rsp_chan.first_skip     = sel.first_skip;
   assign rsp_chan.length_bytes   = sel.length_bytes;
   assign rsp_chan.target_address = sel.target_address;
   assign rsp_chan.final_result   = sel.final_result;

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      second_in    = second_ff;
      if (pop) begin
         cur_in       = head.entry;
         cur_valid_in = 1'b1;
         second_in    = 1'b0;
      end else if (done) begin
         cur_valid_in = 1'b0;
         second_in    = 1'b0;
      end else if (taken) begin
         second_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

### sv/contiguous_read_coalescer_unit.sv
// Read coalescer: each request transaction describes one file block (mapped disk
// block number, leading skip, byte count, destination address, last flag). Blocks
// whose start sector continues the pending device read are merged into it; any
// other mapped block emits the pending read and opens a new one, a hole (block
// number zero) emits the pending read followed by a zero-fill, and the last block
// flushes whatever is pending. One request transaction is accepted every clock
// cycle while the internal queue has room; the response port delivers one
// transaction per cycle while rsp_chan.ready is high, so a request that causes
// two responses uses the port twice and the QUEUE_DEPTH-entry queue absorbs the
// difference. A response is registered in the queue store and then in the back
// end before it is offered. The csr_ port sets log2 of sectors per block (reset
// value 1); the user must write it only while the unit is idle (not enforced).

module contiguous_read_coalescer_unit
   import crcoal_pkg::*;
#(
   parameter int unsigned SECTOR_SHIFT = SECTOR_SHIFT_DEFAULT,
   parameter int unsigned QUEUE_DEPTH  = QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic [2:0]   csr_write_data,
   crcoal_req_if.sink   req_chan,
   crcoal_rsp_if.source rsp_chan
);

   // Configuration register: log2 of sectors per filesystem block.
   logic [2:0] log2_spb_ff;

   // Front end to queue, and queue to back end.
   push_type push;
   logic     push_ready;
   head_type head;
   logic     pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         log2_spb_ff <= LOG2_SPB_RESET;
      end else if (csr_write_enable) begin
         log2_spb_ff <= csr_write_data;
      end
   end

   // The front end holds the pending read, classifies each block as a merge,
   // a new read or a hole, and packs the one or two responses it causes into
   // a single queue entry.
   crcoal_front #(
      .SECTOR_SHIFT (SECTOR_SHIFT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .log2_spb   (log2_spb_ff),
      .req_chan   (req_chan),
      .push_ready (push_ready),
      .push       (push)
   );

   // The queue decouples the front end from stalls on the response side.
   crcoal_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .head       (head),
      .pop        (pop)
   );

   // The back end registers one entry and hands out its responses in order.
   crcoal_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

### sv/crcoal_checker.sv
module crcoal_checker
   import crcoal_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [39:0] rsp_start,
   input logic [15:0] rsp_skip,
   input logic [31:0] rsp_length,
   input logic [31:0] rsp_target,
   input logic        rsp_final
);

   // A stalled response transaction holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_start)
         && $stable(rsp_skip) && $stable(rsp_length) && $stable(rsp_target)
         && $stable(rsp_final))
      else $error("response changed while stalled");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response offered straight after reset");

   // A zero-fill carries no sector and no skip.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ZERO_FILL) |-> (rsp_start == '0) && (rsp_skip == '0))
      else $error("zero-fill with sector or skip");

   // A zero-fill is always the final response of its request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ZERO_FILL) |-> rsp_final)
      else $error("zero-fill not marked final");

endmodule

bind contiguous_read_coalescer_unit crcoal_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_kind   (rsp_chan.request_kind),
   .rsp_start  (rsp_chan.start_sector),
   .rsp_skip   (rsp_chan.first_skip),
   .rsp_length (rsp_chan.length_bytes),
   .rsp_target (rsp_chan.target_address),
   .rsp_final  (rsp_chan.final_result)
);
